// ===== hdl/fpd_pkg.sv =====
package fpd_pkg;

	// Fixed field widths of the channels and configuration registers.
	localparam int SAMPLE_BITS       = 24;
	localparam int PEAK_INDEX_BITS   = 11;
	localparam int MIN_DISTANCE_BITS = 10;
	localparam int SLOT_LIMIT_BITS   = 5;
	localparam int CFG_INDEX_BITS    = 2;
	localparam int CFG_DATA_BITS     = 24;

	// Defaults for the top level's parameters.
	localparam int DEF_FRAME_DEPTH = 1024;
	localparam int DEF_PEAK_SLOTS  = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT_FLOOR = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DISTANCE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOT_LIMIT   = 2'd2;

	// Register values after reset.
	localparam logic signed [SAMPLE_BITS-1:0]   RST_HEIGHT_FLOOR = '0;
	localparam logic [MIN_DISTANCE_BITS-1:0]    RST_MIN_DISTANCE = 10'd1;
	localparam logic [SLOT_LIMIT_BITS-1:0]      RST_SLOT_LIMIT   = 5'd16;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          is_last;
	} fpd_in_t;

	typedef struct packed {
		logic signed [PEAK_INDEX_BITS-1:0] peak_index;
		logic                              last_peak;
	} fpd_out_t;

endpackage

// ===== hdl/fpd_ram.sv =====
module fpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/frame_peak_detector_unit.sv =====
// Frame peak detector.
// Samples arrive on the input channel (in_valid / in_stall), one beat per sample and
// one beat per cycle while the block is loading. The beat with is_last set closes the
// frame; samples past FRAME_DEPTH are dropped, but their is_last still closes the frame.
// After the closing beat the block holds in_stall high while it scans the stored frame
// with a single multiplier: it primes the sample window from the first three samples,
// then takes each interior point through a multiply state (read the next sample and form
// sample*N) and an evaluate state (run the compares and update the peak list). The scan
// ends early once the list holds as many entries as the clamped slot limit. Frames
// shorter than three samples skip the scan. The block then sends one result beat per
// clamped slot on the output channel (out_valid / out_stall), each after a registered
// read of the peak list memory; unused slots carry -1 and the final beat has last_peak set.
// A stalled result stays in the output register and the emission pauses until it is
// taken. New samples are accepted again in the cycle after the final result is loaded.
// Configuration writes (cfg_valid / cfg_ready) are always taken and should only be
// issued while the block is idle; unknown indexes are ignored.
// Reset clears the sequencer, the sample count, the running sum and the output valid,
// and returns the registers to height floor 0, min_distance 1, slot limit 16. The sample
// store is not cleared: only samples of the current frame are ever used.
module frame_peak_detector_unit #(
	parameter int FRAME_DEPTH = fpd_pkg::DEF_FRAME_DEPTH,
	parameter int PEAK_SLOTS  = fpd_pkg::DEF_PEAK_SLOTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  fpd_pkg::fpd_in_t                      in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output fpd_pkg::fpd_out_t                     out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [fpd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	import fpd_pkg::*;

	// Address width of the sample store, also the width of a point index.
	localparam int AW   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	// Sample count width, able to hold FRAME_DEPTH itself.
	localparam int NW   = $clog2(FRAME_DEPTH + 1);
	localparam int NXW  = NW + 1;
	localparam int SUMW = SAMPLE_BITS + NW;
	localparam int PRW  = SUMW + 1;
	localparam int PW   = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
	localparam int CW   = $clog2(PEAK_SLOTS + 1);
	localparam int DW   = (AW > MIN_DISTANCE_BITS) ? AW : MIN_DISTANCE_BITS;
	localparam int XW   = (AW > PEAK_INDEX_BITS) ? AW : PEAK_INDEX_BITS;

	localparam logic [2:0] ST_LOAD    = 3'd0;
	localparam logic [2:0] ST_PRIME   = 3'd1;
	localparam logic [2:0] ST_FILL0   = 3'd2;
	localparam logic [2:0] ST_FILL1   = 3'd3;
	localparam logic [2:0] ST_MUL     = 3'd4;
	localparam logic [2:0] ST_EVAL    = 3'd5;
	localparam logic [2:0] ST_EMIT_RD = 3'd6;
	localparam logic [2:0] ST_EMIT_WR = 3'd7;

	logic [2:0]                   state_q;
	logic signed [SAMPLE_BITS-1:0] height_floor_q;
	logic [MIN_DISTANCE_BITS-1:0] min_distance_q;
	logic [SLOT_LIMIT_BITS-1:0]   slot_limit_q;

	logic [NW-1:0]                cnt_q;
	logic signed [SUMW-1:0]       sum_q;
	logic [AW-1:0]                i_q;
	logic signed [SAMPLE_BITS-1:0] prev_q, cur_q, nxt_q;
	logic signed [PRW-1:0]        prod_q;
	logic [CW-1:0]                pcnt_q;
	logic [CW-1:0]                slots_q;
	logic [AW-1:0]                last_idx_q;
	logic signed [SAMPLE_BITS-1:0] last_val_q;
	logic [CW-1:0]                k_q;
	logic                         out_valid_q;
	fpd_out_t                     out_q;

	logic                         in_acc;
	logic                         cfg_acc;
	logic                         store_ok;
	logic [NW-1:0]                n_next;
	logic [CW-1:0]                slots_clamp;

	logic [AW-1:0]                s_raddr;
	logic [SAMPLE_BITS-1:0]       s_rdata;

	logic signed [NW:0]           n_s;
	logic signed [PRW-1:0]        sum2;
	logic [AW-1:0]                gap;
	logic                         cand;
	logic                         far_enough;
	logic                         do_append;
	logic                         do_replace;
	logic                         list_full;
	logic                         scan_more;

	logic                         p_wen;
	logic [PW-1:0]                p_waddr;
	logic [AW-1:0]                p_rdata;
	logic [XW-1:0]                idx_ext;
	logic                         out_free;
	logic                         final_slot;

	assign in_stall  = (state_q != ST_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// A sample is stored only while the frame has room.
	assign store_ok = (NXW'(cnt_q) < NXW'(FRAME_DEPTH));
	assign n_next   = store_ok ? cnt_q + NW'(1) : cnt_q;

	// A slot count of zero means one; anything above the list size means the full list.
	always_comb begin
		if (slot_limit_q == '0) begin
			slots_clamp = CW'(1);
		end else if (int'(slot_limit_q) > PEAK_SLOTS) begin
			slots_clamp = CW'(PEAK_SLOTS);
		end else begin
			slots_clamp = CW'(slot_limit_q);
		end
	end

	// The store is read one step ahead of the window: while point i is evaluated
	// the sample after its right neighbor is fetched.
	always_comb begin
		case (state_q)
			ST_PRIME: s_raddr = AW'(0);
			ST_FILL0: s_raddr = AW'(1);
			ST_FILL1: s_raddr = AW'(2);
			default:  s_raddr = i_q + AW'(2);
		endcase
	end

	fpd_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(FRAME_DEPTH)
	) u_sample_ram (
		.clk     (clk),
		.wr_en   (in_acc && store_ok),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (in_data.sample),
		.rd_addr (s_raddr),
		.rd_data (s_rdata)
	);

	// Candidate test for the point in cur_q. The mean test compares the product
	// formed in the previous cycle against twice the running sum.
	assign n_s        = {1'b0, cnt_q};
	assign sum2       = $signed({sum_q, 1'b0});
	assign gap        = i_q - last_idx_q;
	assign cand       = (cur_q >= height_floor_q) && (prod_q >= sum2) &&
	                    (cur_q > prev_q) && (cur_q > nxt_q);
	assign far_enough = (DW'(gap) >= DW'(min_distance_q));
	assign do_append  = cand && ((pcnt_q == '0) || far_enough);
	assign do_replace = cand && !do_append && (cur_q > last_val_q);
	assign list_full  = (pcnt_q + CW'(1) == slots_q);
	assign scan_more  = (NXW'(i_q) + NXW'(3) <= NXW'(cnt_q));

	assign p_wen   = (state_q == ST_EVAL) && (do_append || do_replace);
	assign p_waddr = do_append ? pcnt_q[PW-1:0] : PW'(pcnt_q - CW'(1));

	fpd_ram #(
		.WIDTH(AW),
		.DEPTH(PEAK_SLOTS)
	) u_peak_ram (
		.clk     (clk),
		.wr_en   (p_wen),
		.wr_addr (p_waddr),
		.wr_data (i_q),
		.rd_addr (k_q[PW-1:0]),
		.rd_data (p_rdata)
	);

	assign idx_ext    = XW'(p_rdata);
	assign out_free   = !out_valid_q || !out_stall;
	assign final_slot = (k_q + CW'(1) == slots_q);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_floor_q <= RST_HEIGHT_FLOOR;
			min_distance_q <= RST_MIN_DISTANCE;
			slot_limit_q   <= RST_SLOT_LIMIT;
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_HEIGHT_FLOOR: height_floor_q <= $signed(cfg_data[SAMPLE_BITS-1:0]);
				CFG_MIN_DISTANCE: min_distance_q <= cfg_data[MIN_DISTANCE_BITS-1:0];
				CFG_SLOT_LIMIT:   slot_limit_q   <= cfg_data[SLOT_LIMIT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: load, scan, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			sum_q       <= '0;
			pcnt_q      <= '0;
			slots_q     <= '0;
			i_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the emit-write state, that state itself decides the output valid.
			if (out_valid_q && !out_stall && (state_q != ST_EMIT_WR)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (store_ok) begin
							cnt_q <= n_next;
							sum_q <= sum_q + SUMW'(in_data.sample);
						end
						if (in_data.is_last) begin
							pcnt_q  <= '0;
							slots_q <= slots_clamp;
							i_q     <= AW'(1);
							k_q     <= '0;
							state_q <= (NXW'(n_next) < NXW'(3)) ? ST_EMIT_RD : ST_PRIME;
						end
					end
				end
				ST_PRIME: state_q <= ST_FILL0;
				ST_FILL0: state_q <= ST_FILL1;
				ST_FILL1: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_EVAL;
				ST_EVAL: begin
					i_q <= i_q + AW'(1);
					if (do_append) begin
						pcnt_q <= pcnt_q + CW'(1);
					end
					if ((do_append && list_full) || !scan_more) begin
						state_q <= ST_EMIT_RD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_EMIT_RD: state_q <= ST_EMIT_WR;
				ST_EMIT_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						k_q         <= k_q + CW'(1);
						if (final_slot) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Datapath registers of the scan window and the output.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_FILL0: prev_q <= $signed(s_rdata);
			ST_FILL1: cur_q  <= $signed(s_rdata);
			ST_MUL: begin
				nxt_q  <= $signed(s_rdata);
				prod_q <= PRW'(cur_q) * PRW'(n_s);
			end
			ST_EVAL: begin
				if (do_append || do_replace) begin
					last_idx_q <= i_q;
					last_val_q <= cur_q;
				end
				prev_q <= cur_q;
				cur_q  <= nxt_q;
			end
			ST_EMIT_WR: begin
				if (out_free) begin
					out_q.peak_index <= (k_q < pcnt_q) ?
						$signed(idx_ext[PEAK_INDEX_BITS-1:0]) : '1;
					out_q.last_peak  <= final_slot;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
